FILE: design/i2cra_pkg.sv
// shared types and codes for the i2c register access master
// no dependencies; imported by i2c_register_access_master_top
`default_nettype none

package i2cra_pkg;

    // request codes carried in the kind field
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // device address after reset (write bit clear)
    localparam logic [7:0] DEV_ADDR_RESET = 8'hD0;

    // byte counter values
    localparam logic [1:0] BYTE_DEV  = 2'd0;
    localparam logic [1:0] BYTE_REG  = 2'd1;
    localparam logic [1:0] BYTE_LAST = 2'd2;

    // last bit position of a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // bus phases, one per half-period tick
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_TX_LO,
        PH_TX_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_RS_A,
        PH_RS_B,
        PH_RS_C,
        PH_RX_LO,
        PH_RX_HI,
        PH_NAK_LO,
        PH_NAK_HI,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

endpackage

`default_nettype wire

FILE: design/i2c_register_access_master_top.sv
// i2c register access master: bit-level sequencer for one-byte register writes and reads
// depends on i2cra_pkg (phase enum, request codes, reset constants)
`default_nettype none

// One request enters per clock and gives exactly one result; the result reaches the result
// ports through the input register and then the result register once its request is taken,
// and both sides stall independently. Each tick request advances the bus one
// half-period phase; a write request or read request is taken only while idle and
// itself puts out the first start phase. A write takes 59 ticks after the request
// and a read 80; done_res is set on the last of them. Acknowledge bits are clocked
// but not checked. The device address written through cfg_wr_data is used for the
// write address and, plus one, for the read address.
module i2c_register_access_master_top
    import i2cra_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [7:0] s_reg_addr,
    input  wire logic [7:0] s_write_data,
    input  wire logic       s_sda_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_scl_level,
    output logic            m_sda_level,
    output logic            m_sda_drive,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [7:0]      m_read_data
);

    // configuration
    logic [7:0] dev_addr_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [7:0] in_reg_addr_reg;
    logic [7:0] in_write_data_reg;
    logic       in_sda_reg;

    // sequencer state
    phase_t     phase_reg,  phase_next;
    logic [2:0] bit_idx_reg, bit_idx_next;
    logic [7:0] shift_reg,  shift_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] held_addr_reg, held_addr_next;
    logic [7:0] held_data_reg, held_data_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic [1:0] byte_cnt_reg, byte_cnt_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drv_reg, drv_next;
    logic       done_next;

    // result register
    logic       out_valid_reg;
    logic       out_scl_reg;
    logic       out_sda_reg;
    logic       out_drv_reg;
    logic       out_busy_reg;
    logic       out_done_reg;
    logic [7:0] out_rdata_reg;

    // result fields
    logic       res_sda;
    logic       res_busy;

    logic       advance;
    logic       idle;
    logic       is_tick;
    logic       is_request;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign idle    = (phase_reg == PH_IDLE);
    assign is_tick = (in_kind_reg == KIND_TICK);
    assign is_request = (in_kind_reg == KIND_WRITE) || (in_kind_reg == KIND_READ);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end else if (cfg_wr_en) begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg       <= s_kind;
            in_reg_addr_reg   <= s_reg_addr;
            in_write_data_reg <= s_write_data;
            in_sda_reg        <= s_sda_in;
        end
    end

    // next state of the sequencer
    always_comb begin
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        is_read_next   = is_read_reg;
        held_addr_next = held_addr_reg;
        held_data_next = held_data_reg;
        rx_byte_next   = rx_byte_reg;
        byte_cnt_next  = byte_cnt_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drv_next       = drv_reg;
        done_next      = 1'b0;

        if (is_request && idle) begin
            // take a new request and put out the first start phase
            is_read_next   = (in_kind_reg == KIND_READ);
            held_addr_next = in_reg_addr_reg;
            if (in_kind_reg == KIND_WRITE) begin
                held_data_next = in_write_data_reg;
            end
            bit_idx_next  = '0;
            byte_cnt_next = BYTE_DEV;
            phase_next    = PH_START_A;
            scl_next      = 1'b1;
            sda_next      = 1'b1;
            drv_next      = 1'b1;
        end else if (is_tick && !idle) begin
            unique case (phase_reg)
                PH_START_A: begin
                    phase_next = PH_START_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                end
                PH_START_B: begin
                    byte_cnt_next = BYTE_DEV;
                    shift_next    = dev_addr_reg;
                    bit_idx_next  = '0;
                    phase_next    = PH_TX_LO;
                    scl_next      = 1'b0;
                    sda_next      = dev_addr_reg[7];
                    drv_next      = 1'b1;
                end
                PH_TX_LO: begin
                    phase_next = PH_TX_HI;
                    scl_next   = 1'b1;
                    sda_next   = shift_reg[7];
                    drv_next   = 1'b1;
                end
                PH_TX_HI: begin
                    if (bit_idx_reg == LAST_BIT) begin
                        phase_next = PH_ACK_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        drv_next   = 1'b0;
                    end else begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                        shift_next   = {shift_reg[6:0], 1'b0};
                        phase_next   = PH_TX_LO;
                        scl_next     = 1'b0;
                        sda_next     = shift_reg[6];
                        drv_next     = 1'b1;
                    end
                end
                PH_ACK_LO: begin
                    phase_next = PH_ACK_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                end
                PH_ACK_HI: begin
                    // choose what follows the acknowledged byte
                    if (byte_cnt_reg == BYTE_DEV) begin
                        byte_cnt_next = BYTE_REG;
                        shift_next    = held_addr_reg;
                        bit_idx_next  = '0;
                        phase_next    = PH_TX_LO;
                        scl_next      = 1'b0;
                        sda_next      = held_addr_reg[7];
                        drv_next      = 1'b1;
                    end else if (byte_cnt_reg == BYTE_REG) begin
                        byte_cnt_next = BYTE_LAST;
                        if (is_read_reg) begin
                            phase_next = PH_RS_A;
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            drv_next   = 1'b1;
                        end else begin
                            shift_next   = held_data_reg;
                            bit_idx_next = '0;
                            phase_next   = PH_TX_LO;
                            scl_next     = 1'b0;
                            sda_next     = held_data_reg[7];
                            drv_next     = 1'b1;
                        end
                    end else if (is_read_reg) begin
                        shift_next   = '0;
                        bit_idx_next = '0;
                        phase_next   = PH_RX_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                        drv_next     = 1'b0;
                    end else begin
                        phase_next = PH_STOP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        drv_next   = 1'b1;
                    end
                end
                PH_RS_A: begin
                    phase_next = PH_RS_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                end
                PH_RS_B: begin
                    phase_next = PH_RS_C;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                end
                PH_RS_C: begin
                    // read address is the write address plus one, wrapping
                    byte_cnt_next = BYTE_LAST;
                    shift_next    = dev_addr_reg + 8'd1;
                    bit_idx_next  = '0;
                    phase_next    = PH_TX_LO;
                    scl_next      = 1'b0;
                    sda_next      = shift_next[7];
                    drv_next      = 1'b1;
                end
                PH_RX_LO: begin
                    phase_next = PH_RX_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                end
                PH_RX_HI: begin
                    shift_next = {shift_reg[6:0], in_sda_reg};
                    if (bit_idx_reg == LAST_BIT) begin
                        phase_next = PH_NAK_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        drv_next   = 1'b1;
                    end else begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                        phase_next   = PH_RX_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                        drv_next     = 1'b0;
                    end
                end
                PH_NAK_LO: begin
                    phase_next = PH_NAK_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                end
                PH_NAK_HI: begin
                    phase_next = PH_STOP_A;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                end
                PH_STOP_A: begin
                    phase_next = PH_STOP_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                end
                PH_STOP_B: begin
                    phase_next = PH_STOP_C;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                end
                PH_STOP_C: begin
                    if (is_read_reg) begin
                        rx_byte_next = shift_reg;
                    end
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                    done_next  = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                end
            endcase
        end
    end

    // result fields from the updated state
    always_comb begin
        res_sda  = drv_next ? sda_next : 1'b1;
        res_busy = (phase_next != PH_IDLE);
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            is_read_reg   <= 1'b0;
            held_addr_reg <= '0;
            held_data_reg <= '0;
            rx_byte_reg   <= '0;
            byte_cnt_reg  <= BYTE_DEV;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b1;
        end else if (advance) begin
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            is_read_reg   <= is_read_next;
            held_addr_reg <= held_addr_next;
            held_data_reg <= held_data_next;
            rx_byte_reg   <= rx_byte_next;
            byte_cnt_reg  <= byte_cnt_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drv_reg       <= drv_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_scl_reg   <= scl_next;
            out_sda_reg   <= res_sda;
            out_drv_reg   <= drv_next;
            out_busy_reg  <= res_busy;
            out_done_reg  <= done_next;
            out_rdata_reg <= rx_byte_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_level = out_scl_reg;
    assign m_sda_level = out_sda_reg;
    assign m_sda_drive = out_drv_reg;
    assign m_busy_res  = out_busy_reg;
    assign m_done_res  = out_done_reg;
    assign m_read_data = out_rdata_reg;

    // a finished transaction is never reported busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done result still busy");

    // idle sequencer holds the bus released
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (scl_reg && sda_reg && drv_reg))
        else $error("idle bus not released");

    // a tick in the last stop phase finishes the transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_tick && phase_reg == PH_STOP_C)
        |=> (m_valid && m_done_res && phase_reg == PH_IDLE))
        else $error("stop phase did not finish");

    // a result is only replaced after it was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for i2c_register_access_master_top: directed table then random bus transfers
// depends on i2cra_pkg and the block under test; results checked against an in-file model
`timescale 1ns / 100ps

module testbench
    import i2cra_pkg::*;
();

    localparam int         CLK_PERIOD  = 12;
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         PHASE_ITEMS = 200;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result: line levels and status as seen on the result channel
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
    } lines_t;

    // one directed row; typed rows carry their expected lines
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
        logic       sda;
        logic       typed;
        lines_t     lines;
    } row_t;

    localparam lines_t IDLE_LINES    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
    localparam lines_t START_A_LINES = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
    localparam lines_t START_B_LINES = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00};
    localparam lines_t ADDR_MSB_LO   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
    localparam lines_t ADDR_MSB_HI   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};

    localparam int TABLE_ROWS = 16;

    // idle cases, a write start with busy requests mixed in, then plain ticks
    row_t stim_table [0:TABLE_ROWS-1] = '{
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b1, IDLE_LINES},
        '{KIND_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, IDLE_LINES},
        '{KIND_TICK,   8'hFF, 8'hFF, 1'b1, 1'b1, IDLE_LINES},
        '{KIND_WRITE,  8'hFF, 8'h00, 1'b0, 1'b1, START_A_LINES},
        '{KIND_READ,   8'h00, 8'hFF, 1'b1, 1'b1, START_A_LINES},
        '{KIND_UNUSED, 8'h00, 8'h00, 1'b0, 1'b1, START_A_LINES},
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b1, START_B_LINES},
        '{KIND_TICK,   8'h00, 8'h00, 1'b1, 1'b1, ADDR_MSB_LO},
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b1, ADDR_MSB_HI},
        '{KIND_WRITE,  8'h5A, 8'hA5, 1'b1, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b1, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b1, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b1, 1'b0, '0},
        '{KIND_TICK,   8'h00, 8'h00, 1'b0, 1'b0, '0}
    };

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_kind;
    logic [7:0] s_reg_addr;
    logic [7:0] s_write_data;
    logic       s_sda_in;
    logic       m_valid;
    logic       m_ready;
    logic       m_scl_level;
    logic       m_sda_level;
    logic       m_sda_drive;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_data;

    // bus model state
    phase_t     bus_phase;
    logic [2:0] bit_pos;
    logic [7:0] shift_reg;
    logic       read_op;
    logic [7:0] held_reg;
    logic [7:0] held_data;
    logic [7:0] rx_byte;
    logic [1:0] byte_num;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic [7:0] dev_addr;

    lines_t expected_lines_q [$];

    int send_idle;
    int recv_stall;
    int error_count;
    int checked_count;
    int request_count;
    int write_count;
    int read_count;
    int cycle_count;

    i2c_register_access_master_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_reg_addr   (s_reg_addr),
        .s_write_data (s_write_data),
        .s_sda_in     (s_sda_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_level  (m_scl_level),
        .m_sda_level  (m_sda_level),
        .m_sda_drive  (m_sda_drive),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_read_data  (m_read_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall);
    end

    function void drive_bus(input logic scl, input logic sda, input logic drv);
        scl_q = scl;
        sda_q = sda;
        drv_q = drv;
    endfunction

    function void load_tx(input logic [7:0] b);
        shift_reg = b;
        bit_pos   = '0;
        bus_phase = PH_TX_LO;
        drive_bus(1'b0, b[7], 1'b1);
    endfunction

    // one half-period step of the sequencer; returns 1 on the closing stop phase
    function logic advance_bus(input logic sda);
        case (bus_phase)
            PH_START_A: begin
                bus_phase = PH_START_B;
                drive_bus(1'b1, 1'b0, 1'b1);
            end
            PH_START_B: begin
                byte_num = BYTE_DEV;
                load_tx(dev_addr);
            end
            PH_TX_LO: begin
                bus_phase = PH_TX_HI;
                drive_bus(1'b1, shift_reg[7], 1'b1);
            end
            PH_TX_HI: begin
                if (bit_pos >= LAST_BIT) begin
                    bus_phase = PH_ACK_LO;
                    drive_bus(1'b0, 1'b1, 1'b0);
                end else begin
                    bit_pos   = bit_pos + 3'd1;
                    shift_reg = shift_reg << 1;
                    bus_phase = PH_TX_LO;
                    drive_bus(1'b0, shift_reg[7], 1'b1);
                end
            end
            PH_ACK_LO: begin
                bus_phase = PH_ACK_HI;
                drive_bus(1'b1, 1'b1, 1'b0);
            end
            PH_ACK_HI: begin
                if (byte_num == BYTE_DEV) begin
                    byte_num = BYTE_REG;
                    load_tx(held_reg);
                end else if (byte_num == BYTE_REG) begin
                    byte_num = BYTE_LAST;
                    if (read_op) begin
                        bus_phase = PH_RS_A;
                        drive_bus(1'b0, 1'b1, 1'b1);
                    end else begin
                        load_tx(held_data);
                    end
                end else if (read_op) begin
                    shift_reg = '0;
                    bit_pos   = '0;
                    bus_phase = PH_RX_LO;
                    drive_bus(1'b0, 1'b1, 1'b0);
                end else begin
                    bus_phase = PH_STOP_A;
                    drive_bus(1'b0, 1'b0, 1'b1);
                end
            end
            PH_RS_A: begin
                bus_phase = PH_RS_B;
                drive_bus(1'b1, 1'b1, 1'b1);
            end
            PH_RS_B: begin
                bus_phase = PH_RS_C;
                drive_bus(1'b1, 1'b0, 1'b1);
            end
            PH_RS_C: begin
                byte_num = BYTE_LAST;
                load_tx(dev_addr + 8'd1);
            end
            PH_RX_LO: begin
                bus_phase = PH_RX_HI;
                drive_bus(1'b1, 1'b1, 1'b0);
            end
            PH_RX_HI: begin
                shift_reg = {shift_reg[6:0], sda};
                if (bit_pos >= LAST_BIT) begin
                    bus_phase = PH_NAK_LO;
                    drive_bus(1'b0, 1'b1, 1'b1);
                end else begin
                    bit_pos   = bit_pos + 3'd1;
                    bus_phase = PH_RX_LO;
                    drive_bus(1'b0, 1'b1, 1'b0);
                end
            end
            PH_NAK_LO: begin
                bus_phase = PH_NAK_HI;
                drive_bus(1'b1, 1'b1, 1'b1);
            end
            PH_NAK_HI: begin
                bus_phase = PH_STOP_A;
                drive_bus(1'b0, 1'b0, 1'b1);
            end
            PH_STOP_A: begin
                bus_phase = PH_STOP_B;
                drive_bus(1'b1, 1'b0, 1'b1);
            end
            PH_STOP_B: begin
                bus_phase = PH_STOP_C;
                drive_bus(1'b1, 1'b1, 1'b1);
            end
            PH_STOP_C: begin
                if (read_op)
                    rx_byte = shift_reg;
                bus_phase = PH_IDLE;
                drive_bus(1'b1, 1'b1, 1'b1);
                return 1'b1;
            end
            default: begin
                bus_phase = PH_IDLE;
                drive_bus(1'b1, 1'b1, 1'b1);
            end
        endcase
        return 1'b0;
    endfunction

    // expected lines for one accepted request
    function lines_t predict_lines(input logic [1:0] kind, input logic [7:0] ra,
                                   input logic [7:0] wd, input logic sda);
        lines_t r;
        logic   fin;
        fin = 1'b0;
        if (kind == KIND_TICK) begin
            if (bus_phase != PH_IDLE)
                fin = advance_bus(sda);
        end else if ((kind == KIND_WRITE || kind == KIND_READ) && bus_phase == PH_IDLE) begin
            read_op  = (kind == KIND_READ);
            held_reg = ra;
            if (kind == KIND_WRITE)
                held_data = wd;
            bit_pos   = '0;
            byte_num  = BYTE_DEV;
            bus_phase = PH_START_A;
            drive_bus(1'b1, 1'b1, 1'b1);
            if (read_op)
                read_count++;
            else
                write_count++;
        end
        r.scl   = scl_q;
        r.sda   = drv_q ? sda_q : 1'b1;
        r.drive = drv_q;
        r.busy  = (bus_phase != PH_IDLE);
        r.done  = fin;
        r.rdata = rx_byte;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        lines_t want;
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (expected_lines_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual scl %b sda %b drv %b",
                         $time, m_scl_level, m_sda_level, m_sda_drive);
                error_count++;
            end else begin
                want = expected_lines_q.pop_front();
                report_field("scl_level", 8'(want.scl),   8'(m_scl_level));
                report_field("sda_level", 8'(want.sda),   8'(m_sda_level));
                report_field("sda_drive", 8'(want.drive), 8'(m_sda_drive));
                report_field("busy_res",  8'(want.busy),  8'(m_busy_res));
                report_field("done_res",  8'(want.done),  8'(m_done_res));
                report_field("read_data", want.rdata,     m_read_data);
            end
        end
    end

    // send one request, wait for it to be taken, queue its expected lines
    task automatic send_item(input logic [1:0] kind, input logic [7:0] ra,
                             input logic [7:0] wd, input logic sda,
                             input logic use_typed = 1'b0, input lines_t typed_lines = '0);
        lines_t pred;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_kind       = kind;
        s_reg_addr   = ra;
        s_write_data = wd;
        s_sda_in     = sda;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = predict_lines(kind, ra, wd, sda);
        expected_lines_q.push_back(use_typed ? typed_lines : pred);
        request_count++;
    endtask

    // hold the sender until every expected result is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_lines_q.size() != 0)
            @(posedge aclk);
    endtask

    // tick the bus until the transfer ends, with stray requests now and then
    task automatic finish_transfer(input int sda_mode, input logic pause_midway);
        int   tick_no;
        logic sda_bit;
        tick_no = 0;
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(19) == 0) begin
                send_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                sda_bit = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom);
                send_item(KIND_TICK, 8'($urandom), 8'($urandom), sda_bit);
            end
            tick_no++;
            if (pause_midway && tick_no == 30)
                drain_results();
        end
    endtask

    // one phase: new device address, idling mix, then random transfers and noise
    task automatic run_phase(input logic [7:0] addr, input int idle_pct,
                             input int stall_pct, input logic pause_once);
        int   start_count;
        logic [1:0] req_kind;
        drain_results();
        repeat (8) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = addr;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        dev_addr    = addr;
        send_idle   = idle_pct;
        recv_stall  = stall_pct;
        start_count = request_count;
        while (request_count - start_count < PHASE_ITEMS) begin
            // idle noise: ticks and unused kinds with nothing in flight
            repeat ($urandom_range(2))
                send_item($urandom_range(1) ? KIND_TICK : KIND_UNUSED,
                          8'($urandom), 8'($urandom), 1'($urandom));
            req_kind = $urandom_range(1) ? KIND_READ : KIND_WRITE;
            send_item(req_kind, 8'($urandom), 8'($urandom), 1'($urandom));
            finish_transfer($urandom_range(3), pause_once);
            pause_once = 1'b0;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_kind       = KIND_TICK;
        s_reg_addr   = '0;
        s_write_data = '0;
        s_sda_in     = 1'b0;
        m_ready      = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        error_count  = 0;
        checked_count = 0;
        request_count = 0;
        write_count  = 0;
        read_count   = 0;
        cycle_count  = 0;

        // model reset state
        dev_addr  = DEV_ADDR_RESET;
        bus_phase = PH_IDLE;
        bit_pos   = '0;
        shift_reg = '0;
        read_op   = 1'b0;
        held_reg  = '0;
        held_data = '0;
        rx_byte   = '0;
        byte_num  = BYTE_DEV;
        drive_bus(1'b1, 1'b1, 1'b1);

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // directed rows at the reset address
        for (int i = 0; i < TABLE_ROWS; i++)
            send_item(stim_table[i].kind, stim_table[i].reg_addr, stim_table[i].wdata,
                      stim_table[i].sda, stim_table[i].typed, stim_table[i].lines);
        finish_transfer(2, 1'b0);

        // random transfers over four address settings and idling mixes
        run_phase(8'h00, 0, 0, 1'b0);
        run_phase(8'hFE, 80, 0, 1'b0);
        run_phase(8'hFF, 0, 80, 1'b1);
        run_phase(8'($urandom_range(254)), 17, 17, 1'b0);

        drain_results();
        repeat (10) @(posedge aclk);

        $display("covered %0d requests: %0d writes, %0d reads started", request_count,
                 write_count, read_count);
        $display("checked %0d results over four device addresses incl. wrap", checked_count);
        if (error_count == 0 && expected_lines_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
